// ===== design/assert_macros.svh =====
// Assertion helpers used by krt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KRT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("krt assertion failed");

// Next-cycle implication.
`define KRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("krt assertion failed");

`endif

// ===== design/krt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package krt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int KEY_W   = 16;
  localparam int GRADE_W = 8;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [GRADE_W-1:0] grade_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_MODIFY = 3'd3,
    CMD_LOOKUP = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic exec;
  } krt_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } krt_sts_t;

  // Report the low bits of a slot number.
  function automatic slot_t to_slot(input idx_t idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = {{SLOT_W{1'b0}}, idx};
    return ext[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/krt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module krt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  krt_pkg::krt_sts_t sts,
  output krt_pkg::krt_ctl_t ctl
);
  import krt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          ctl.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.step = 1'b1;
        if (sts.scan_last) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // hold the write-back until the result register frees up
        if (!sts.out_busy) begin
          ctl.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    in_tready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;

endmodule

`default_nettype wire

// ===== design/krt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module krt_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [krt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [krt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  krt_pkg::krt_ctl_t              ctl,
  output krt_pkg::krt_sts_t              sts
);
  import krt_pkg::*;

  logic [TABLE_DEPTH-1:0] valid_r;
  key_t                   key_mem   [TABLE_DEPTH];
  grade_t                 grade_mem [TABLE_DEPTH];

  logic [CMD_W-1:0] cmd_r;
  key_t             key_r;
  grade_t           grade_r;

  idx_t   scan_idx_r;
  logic   free_found_r;
  idx_t   free_idx_r;
  logic   match_found_r;
  idx_t   match_idx_r;
  grade_t match_grade_r;
  logic   any_valid_r;

  logic    out_valid_r;
  status_t out_status_r;
  slot_t   out_slot_r;
  grade_t  out_grade_r;

  logic    cur_valid;
  logic    cur_hit;

  status_t res_status;
  slot_t   res_slot;
  grade_t  res_grade;
  logic    do_clear;
  logic    do_insert;
  logic    do_delete;
  logic    do_modify;

  assign cur_valid = valid_r[scan_idx_r];
  assign cur_hit   = cur_valid && (key_mem[scan_idx_r] == key_r);

  assign sts.scan_last = (scan_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign sts.out_busy  = out_valid_r && !out_tready;

  // Decide the outcome from what the scan left behind.
  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_grade  = '0;
    do_clear   = 1'b0;
    do_insert  = 1'b0;
    do_delete  = 1'b0;
    do_modify  = 1'b0;
    case (cmd_r)
      CMD_CLEAR: do_clear = 1'b1;
      CMD_INSERT: begin
        if (!free_found_r) begin
          res_status = ST_FULL;
        end else if (match_found_r) begin
          res_status = ST_DUP;
        end else begin
          do_insert = 1'b1;
          res_slot  = to_slot(free_idx_r);
          res_grade = grade_r;
        end
      end
      CMD_DELETE, CMD_MODIFY, CMD_LOOKUP: begin
        if (!any_valid_r) begin
          res_status = ST_EMPTY;
        end else if (!match_found_r) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_slot = to_slot(match_idx_r);
          if (cmd_r == CMD_DELETE) begin
            do_delete = 1'b1;
          end else if (cmd_r == CMD_MODIFY) begin
            do_modify = 1'b1;
            res_grade = grade_r;
          end else begin
            res_grade = match_grade_r;
          end
        end
      end
      default: ;
    endcase
  end

  // Request and scan registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r         <= in_tdata[2:0];
      key_r         <= in_tdata[18:3];
      grade_r       <= in_tdata[26:19];
      scan_idx_r    <= '0;
      free_found_r  <= 1'b0;
      match_found_r <= 1'b0;
      any_valid_r   <= 1'b0;
    end else if (ctl.step) begin
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= scan_idx_r;
      end
      if (cur_valid) any_valid_r <= 1'b1;
      // keep the first hit only
      if (cur_hit && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= scan_idx_r;
        match_grade_r <= grade_mem[scan_idx_r];
      end
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.exec) begin
      if (do_clear) valid_r <= '0;
      if (do_insert) valid_r[free_idx_r] <= 1'b1;
      if (do_delete) valid_r[match_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec && do_insert) begin
      key_mem[free_idx_r]   <= key_r;
      grade_mem[free_idx_r] <= grade_r;
    end else if (ctl.exec && do_modify) begin
      grade_mem[match_idx_r] <= grade_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_grade_r  <= res_grade;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_grade_r, out_slot_r, out_status_r};

endmodule

`default_nettype wire

// ===== design/keyed_record_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Signals                           Payload
// in       in   in_tvalid/in_tready/in_tdata      command, record_key, grade_in
// out      out  out_tvalid/out_tready/out_tdata   status, slot_index, grade_out
//
// Each request is accepted, then the 16 slots of the single-ported slot table
// are scanned in turn, then the write-back loads the result register. One
// request is in flight at a time.
// A waiting result holds the write-back stage until out_tready; the input
// stays stalled meanwhile. Reset frees every slot.

module keyed_record_table_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [2:0] command, [18:3] record_key, [26:19] grade_in, [31:27] zero
  input  logic [krt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] status, [6:3] slot_index, [14:7] grade_out, [15] zero
  output logic [krt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import krt_pkg::*;

  krt_ctl_t ctl;
  krt_sts_t sts;

  krt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  krt_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .ctl        (ctl),
    .sts        (sts)
  );

endmodule

`default_nettype wire

// ===== design/krt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module krt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [krt_pkg::OUT_DATA_W-1:0] out_tdata
);
  import krt_pkg::*;

  `KRT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `KRT_ASSERT(a_status_code, out_tvalid,
    out_tdata[2:0] == ST_OK || out_tdata[2:0] == ST_FULL || out_tdata[2:0] == ST_DUP ||
    out_tdata[2:0] == ST_NOTFOUND || out_tdata[2:0] == ST_EMPTY)
  `KRT_ASSERT(a_fail_zero, out_tvalid && out_tdata[2:0] != ST_OK, out_tdata[14:3] == 12'd0)
  `KRT_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
